// ===== rtl/core/imuc_pkg.sv =====
// Shared types, widths and constants for the IMU tilt complementary filter.
// No dependencies; every other file of the block imports this package.
package imuc_pkg;

  localparam int AccW     = 16;  // accelerometer count width
  localparam int RateW    = 24;  // gyro rate width, Q15.8
  localparam int AngW     = 32;  // filtered angle width, Q15.16
  localparam int AxW      = 17;  // remapped axis; holds +32768
  localparam int SqW      = 31;  // square of one axis
  localparam int SumW     = 32;  // sum of two squares
  localparam int OpW      = 48;  // root operand, sum shifted up by 16
  localparam int RootW    = 24;  // floor square root, Q.8 magnitude
  localparam int RemW     = 27;  // partial remainder of the root
  localparam int CorW     = 28;  // rotation X and Y
  localparam int CzW      = 26;  // accumulated angle, degrees Q.16
  localparam int StepW    = 5;   // iteration counter
  localparam int RootSteps   = 24;
  localparam int CordicSteps = 18;
  localparam int PrW      = 45;  // rate times time step
  localparam int GW       = 34;  // gyro-integrated angle
  localparam int SW       = 52;  // weighted sum
  localparam int Deg90    = 90 * 65536;

  localparam int GyroWW   = 16;
  localparam int AccelWW  = 16;
  localparam int TimeStepW = 20;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  localparam int QueueDepthDef = 2;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegGyroWeight  = 2'd0;
  localparam logic [1:0] RegAccelWeight = 2'd1;
  localparam logic [1:0] RegTimeStep    = 2'd2;

  localparam logic [GyroWW-1:0]    GyroWeightRst  = 16'd64225;
  localparam logic [AccelWW-1:0]   AccelWeightRst = 16'd1311;
  localparam logic [TimeStepW-1:0] TimeStepRst    = 20'd10486;

  typedef struct packed {
    logic        [GyroWW-1:0]    gyro_weight;
    logic        [AccelWW-1:0]   accel_weight;
    logic        [TimeStepW-1:0] time_step;
  } imuc_cfg_t;

  // One queued sample with the accelerometer axes already remapped.
  typedef struct packed {
    logic signed [AxW-1:0]   ax;
    logic signed [AxW-1:0]   ay;
    logic signed [AxW-1:0]   az;
    logic signed [RateW-1:0] rate_x;
    logic signed [RateW-1:0] rate_y;
    logic signed [RateW-1:0] rate_z;
  } imuc_item_t;

  // atan(2^-i) in degrees, Q.16, rounded to nearest.
  function automatic logic signed [CzW-1:0] atan_lut(input logic [StepW-1:0] i);
    logic signed [CzW-1:0] v;
    case (i)
      5'd0:    v = 26'sd2949120;
      5'd1:    v = 26'sd1740967;
      5'd2:    v = 26'sd919879;
      5'd3:    v = 26'sd466945;
      5'd4:    v = 26'sd234379;
      5'd5:    v = 26'sd117304;
      5'd6:    v = 26'sd58666;
      5'd7:    v = 26'sd29335;
      5'd8:    v = 26'sd14668;
      5'd9:    v = 26'sd7334;
      5'd10:   v = 26'sd3667;
      5'd11:   v = 26'sd1833;
      5'd12:   v = 26'sd917;
      5'd13:   v = 26'sd458;
      5'd14:   v = 26'sd229;
      5'd15:   v = 26'sd115;
      5'd16:   v = 26'sd57;
      5'd17:   v = 26'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/imuc_if.sv =====
// Handshake channel interfaces for the IMU tilt filter: samples in, angles out.
// Depends on imuc_pkg for the field widths.
interface imuc_in_if import imuc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [AccW-1:0] accel_x;
  logic signed [AccW-1:0] accel_y;
  logic signed [AccW-1:0] accel_z;
  logic signed [RateW-1:0] rate_x;
  logic signed [RateW-1:0] rate_y;
  logic signed [RateW-1:0] rate_z;

  modport source(output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                 input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
               output ready);
endinterface

interface imuc_out_if import imuc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [AngW-1:0] angle_x;
  logic signed [AngW-1:0] angle_y;
  logic signed [AngW-1:0] angle_z;

  modport source(output valid, angle_x, angle_y, angle_z, input ready);
  modport sink(input valid, angle_x, angle_y, angle_z, output ready);
endinterface

// ===== rtl/core/imuc_front.sv =====
// Front end: takes input words, remaps the accelerometer axes and drops
// samples with an all-zero gravity vector. Depends on imuc_pkg and imuc_if.
module imuc_front import imuc_pkg::*; (
  imuc_in_if.sink    in_chan,
  input  logic       q_full,
  output logic       push,
  output imuc_item_t push_item
);

  logic signed [AxW-1:0] ay_ext;
  logic                  accel_zero;

  always_comb begin
    ay_ext     = AxW'(in_chan.accel_y);
    accel_zero = (in_chan.accel_x == '0) && (in_chan.accel_y == '0) &&
                 (in_chan.accel_z == '0);

    push_item.ax     = -ay_ext;
    push_item.ay     = AxW'(in_chan.accel_x);
    push_item.az     = AxW'(in_chan.accel_z);
    push_item.rate_x = in_chan.rate_x;
    push_item.rate_y = in_chan.rate_y;
    push_item.rate_z = in_chan.rate_z;

    in_chan.ready = !q_full;
    push          = in_chan.valid && !q_full && !accel_zero;
  end

endmodule

// ===== rtl/core/imuc_queue.sv =====
// Short queue of classified samples between the front end and the back end.
// Depends on imuc_pkg for the item type.
module imuc_queue import imuc_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  imuc_item_t push_item,
  input  logic       pop,
  output imuc_item_t pop_item,
  output logic       full,
  output logic       empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  imuc_item_t        mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r;
  logic [PtrW-1:0]   rd_ptr_r;
  logic [CntW-1:0]   count_r;

  assign full     = (count_r == CntW'(Depth));
  assign empty    = (count_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/imuc_back.sv =====
// Back end: three-lane square root and CORDIC arctangent, then the per-axis
// complementary blend and the output register. Depends on imuc_pkg, imuc_if.
module imuc_back import imuc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  imuc_cfg_t  cfg,
  input  logic       q_empty,
  input  imuc_item_t q_item,
  output logic       pop,
  imuc_out_if.source out_chan
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQR, ST_RINIT, ST_ROOT, ST_PREP, ST_ROT,
    ST_RMUL, ST_GADD, ST_AMUL, ST_BMUL, ST_SUM, ST_FIN
  } state_t;

  state_t                 st_r;
  logic [StepW-1:0]       step_r;
  logic [1:0]             axis_r;
  imuc_item_t             item_r;

  logic [SqW-1:0]         sq_r   [3];
  logic [OpW-1:0]         opnd_r [3];
  logic [RemW-1:0]        rem_r  [3];
  logic [RootW-1:0]       root_r [3];
  logic signed [CorW-1:0] x_r    [3];
  logic signed [CorW-1:0] y_r    [3];
  logic signed [CzW-1:0]  z_r    [3];
  logic                   spec_r [3];
  logic                   npos_r [3];
  logic                   zneg_r;

  logic signed [AngW-1:0] ang_r  [3];
  logic signed [PrW-1:0]  prod_r;
  logic signed [GW-1:0]   g_r;
  logic signed [SW-1:0]   pa_r;
  logic signed [SW-1:0]   pb_r;
  logic                   out_valid_r;
  logic signed [AngW-1:0] out_ang_r [3];

  // Combinational helpers.
  logic signed [2*AxW-1:0] sqp    [3];
  logic [SumW-1:0]         sum_c  [3];
  logic [RemW-1:0]         rsh_c  [3];
  logic [RemW-1:0]         trial_c[3];
  logic signed [CorW-1:0]  num_c  [3];
  logic signed [CorW-1:0]  den_c  [3];
  logic signed [CorW-1:0]  xs_c   [3];
  logic signed [CorW-1:0]  ys_c   [3];
  logic signed [CzW-1:0]   atan_c;
  logic signed [AxW-1:0]   az_abs;
  logic signed [RateW-1:0] rate_k;
  logic signed [PrW-1:0]   prod_c;
  logic signed [PrW-1:0]   prr_c;
  logic signed [GW-1:0]    g_c;
  logic signed [CzW-1:0]   acc_k;
  logic signed [SW-1:0]    pa_c;
  logic signed [SW-1:0]    pb_c;
  logic signed [SW-1:0]    s_c;
  logic signed [SW-1:0]    t_c;
  logic signed [AngW-1:0]  sat_c;

  assign pop              = (st_r == ST_IDLE) && !q_empty;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.angle_x = out_ang_r[0];
  assign out_chan.angle_y = out_ang_r[1];
  assign out_chan.angle_z = out_ang_r[2];

  always_comb begin
    sqp[0] = $signed(item_r.ax) * $signed(item_r.ax);
    sqp[1] = $signed(item_r.ay) * $signed(item_r.ay);
    sqp[2] = $signed(item_r.az) * $signed(item_r.az);
    sum_c[0] = SumW'(sq_r[1]) + SumW'(sq_r[2]);
    sum_c[1] = SumW'(sq_r[0]) + SumW'(sq_r[2]);
    sum_c[2] = SumW'(sq_r[0]) + SumW'(sq_r[1]);

    az_abs   = item_r.az[AxW-1] ? -item_r.az : item_r.az;
    num_c[0] = CorW'(item_r.ax) <<< 8;
    num_c[1] = CorW'(item_r.ay) <<< 8;
    num_c[2] = $signed(CorW'(root_r[2]));
    den_c[0] = $signed(CorW'(root_r[0]));
    den_c[1] = $signed(CorW'(root_r[1]));
    den_c[2] = CorW'(az_abs) <<< 8;

    atan_c = atan_lut(step_r);
    for (int k = 0; k < 3; k++) begin
      rsh_c[k]   = {rem_r[k][RemW-3:0], opnd_r[k][OpW-1 -: 2]};
      trial_c[k] = RemW'({root_r[k], 2'b01});
      xs_c[k]    = x_r[k] >>> step_r;
      ys_c[k]    = y_r[k] >>> step_r;
    end

    case (axis_r)
      2'd0:    rate_k = item_r.rate_x;
      2'd1:    rate_k = item_r.rate_y;
      default: rate_k = item_r.rate_z;
    endcase
    prod_c = rate_k * $signed({1'b0, cfg.time_step});
    prr_c  = prod_r + $signed(PrW'(2048));
    g_c    = GW'(ang_r[axis_r]) + GW'(prr_c >>> 12);

    if (spec_r[axis_r]) begin
      acc_k = npos_r[axis_r] ? CzW'(Deg90) : -CzW'(Deg90);
    end else if ((axis_r == 2'd2) && zneg_r) begin
      acc_k = -z_r[axis_r];
    end else begin
      acc_k = z_r[axis_r];
    end
    pa_c = $signed({1'b0, cfg.gyro_weight}) * g_r;
    pb_c = $signed({1'b0, cfg.accel_weight}) * acc_k;

    s_c = pa_r + pb_r + $signed(SW'(32768));
    t_c = s_c >>> 16;
    if (t_c[SW-1:AngW-1] == {(SW-AngW+1){t_c[SW-1]}}) begin
      sat_c = t_c[AngW-1:0];
    end else begin
      sat_c = t_c[SW-1] ? {1'b1, {(AngW-1){1'b0}}} : {1'b0, {(AngW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      step_r      <= '0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        ang_r[k] <= '0;
      end
    end else begin
      // In the final state the output register is handled below.
      if (out_valid_r && out_chan.ready && (st_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (!q_empty) begin
            item_r <= q_item;
            st_r   <= ST_SQR;
          end
        end
        ST_SQR: begin
          for (int k = 0; k < 3; k++) begin
            sq_r[k] <= SqW'(sqp[k]);
          end
          st_r <= ST_RINIT;
        end
        ST_RINIT: begin
          for (int k = 0; k < 3; k++) begin
            opnd_r[k] <= {sum_c[k], 16'b0};
            rem_r[k]  <= '0;
            root_r[k] <= '0;
          end
          step_r <= '0;
          st_r   <= ST_ROOT;
        end
        ST_ROOT: begin
          // One result bit per lane and cycle, restoring method.
          for (int k = 0; k < 3; k++) begin
            opnd_r[k] <= opnd_r[k] << 2;
            if (rsh_c[k] >= trial_c[k]) begin
              rem_r[k]  <= rsh_c[k] - trial_c[k];
              root_r[k] <= {root_r[k][RootW-2:0], 1'b1};
            end else begin
              rem_r[k]  <= rsh_c[k];
              root_r[k] <= {root_r[k][RootW-2:0], 1'b0};
            end
          end
          if (step_r == StepW'(RootSteps - 1)) begin
            st_r <= ST_PREP;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_PREP: begin
          for (int k = 0; k < 3; k++) begin
            x_r[k]    <= den_c[k];
            y_r[k]    <= num_c[k];
            z_r[k]    <= '0;
            spec_r[k] <= (den_c[k] == '0);
            npos_r[k] <= (num_c[k] > 0);
          end
          zneg_r <= item_r.az[AxW-1];
          step_r <= '0;
          st_r   <= ST_ROT;
        end
        ST_ROT: begin
          for (int k = 0; k < 3; k++) begin
            if (!y_r[k][CorW-1]) begin
              x_r[k] <= x_r[k] + ys_c[k];
              y_r[k] <= y_r[k] - xs_c[k];
              z_r[k] <= z_r[k] + atan_c;
            end else begin
              x_r[k] <= x_r[k] - ys_c[k];
              y_r[k] <= y_r[k] + xs_c[k];
              z_r[k] <= z_r[k] - atan_c;
            end
          end
          if (step_r == StepW'(CordicSteps - 1)) begin
            axis_r <= '0;
            st_r   <= ST_RMUL;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_RMUL: begin
          prod_r <= prod_c;
          st_r   <= ST_GADD;
        end
        ST_GADD: begin
          g_r  <= g_c;
          st_r <= ST_AMUL;
        end
        ST_AMUL: begin
          pa_r <= pa_c;
          st_r <= ST_BMUL;
        end
        ST_BMUL: begin
          pb_r <= pb_c;
          st_r <= ST_SUM;
        end
        ST_SUM: begin
          ang_r[axis_r] <= sat_c;
          if (axis_r == 2'd2) begin
            st_r <= ST_FIN;
          end else begin
            axis_r <= axis_r + 1'b1;
            st_r   <= ST_RMUL;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_chan.ready) begin
            for (int k = 0; k < 3; k++) begin
              out_ang_r[k] <= ang_r[k];
            end
            out_valid_r <= 1'b1;
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ROOT) |-> (step_r < StepW'(RootSteps)))
    else $error("root iteration count out of range");

  a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ROT) |-> (step_r < StepW'(CordicSteps)))
    else $error("rotation step count out of range");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (st_r == ST_SQR))
    else $error("sample taken from queue outside idle");

  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN && !out_valid_r) |=> (out_valid_r && st_r == ST_IDLE))
    else $error("finished word not presented");

endmodule

// ===== rtl/core/imu_tilt_complementary_filter.sv =====
// Top level of the IMU tilt complementary filter: configuration registers,
// front end, sample queue and back end. Depends on imuc_pkg and imuc_if.
//
// Each accepted input word is one IMU sample (three accelerometer counts and
// three gyro rates). A sample whose accelerometer vector is all zero is
// dropped with no result and no change of the stored angles. Every other
// sample produces exactly one output word with the three filtered angles in
// Q15.16 degrees. In the back end a sample leaves the queue, the squares are
// formed, the root operands are loaded, the 24-bit bit-serial square roots
// run (one bit per cycle, three lanes side by side), the rotators are loaded,
// 18 CORDIC iterations run, five steps per axis do the rate integration and
// weighted blend of the three axes taken in turn, and the output register is
// loaded once it is free. The front end keeps accepting words into a small
// queue while the back end works, and a finished word may wait in the output
// register while the next sample is already being processed. Configuration
// is written through an APB-style port at byte addresses 0 (gyro weight), 4
// (accel weight) and 8 (time step); a write at 12 is ignored, and the two low
// address bits are not decoded. Registers should only be written while the
// block is idle.
module imu_tilt_complementary_filter import imuc_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  imuc_in_if.sink             in_chan,
  imuc_out_if.source          out_chan,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  imuc_cfg_t  cfg_r;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  imuc_item_t q_in_item;
  imuc_item_t q_out_item;

  // Register block: written in the access phase, reads are always ready.
  assign pready  = 1'b1;
  assign reg_idx = paddr[CfgAddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gyro_weight  <= GyroWeightRst;
      cfg_r.accel_weight <= AccelWeightRst;
      cfg_r.time_step    <= TimeStepRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegGyroWeight:  cfg_r.gyro_weight  <= pwdata[GyroWW-1:0];
        RegAccelWeight: cfg_r.accel_weight <= pwdata[AccelWW-1:0];
        RegTimeStep:    cfg_r.time_step    <= pwdata[TimeStepW-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegGyroWeight:  prdata = CfgDataW'(cfg_r.gyro_weight);
      RegAccelWeight: prdata = CfgDataW'(cfg_r.accel_weight);
      RegTimeStep:    prdata = CfgDataW'(cfg_r.time_step);
      default:        prdata = '0;
    endcase
  end

  // The front end remaps axes and filters out degenerate samples.
  imuc_front u_front (
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (q_push),
    .push_item (q_in_item)
  );

  imuc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  // The back end owns the filter state and the output register.
  imuc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_item   (q_out_item),
    .pop      (q_pop),
    .out_chan (out_chan)
  );

endmodule

// ===== tb/sv/imu_tilt_complementary_filter_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the IMU tilt filter: it watches both word channels and the
// configuration port and predicts every result. Depends on imuc_pkg, imuc_if.
module imu_tilt_complementary_filter_checker import imuc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  imuc_in_if                  in_mon,
  imuc_out_if                 out_mon,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output int                  fail_count,
  output int                  angles_pending
);

  typedef struct packed {
    logic signed [AngW-1:0] ax;
    logic signed [AngW-1:0] ay;
    logic signed [AngW-1:0] az;
  } angles_t;

  logic [GyroWW-1:0]    alpha;
  logic [AccelWW-1:0]   beta;
  logic [TimeStepW-1:0] dt;
  logic signed [AngW-1:0] held [3];
  angles_t expected_angles [$];

  function automatic longint floor_root(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint atan_table(int i);
    longint t [18] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                       29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
    return t[i];
  endfunction

  // Vectoring rotation; den is never negative here.
  function automatic longint tilt_deg(longint num, longint den);
    longint x;
    longint y;
    longint z;
    longint nx;
    if (den == 0) return (num > 0) ? longint'(Deg90) : -longint'(Deg90);
    x = den;
    y = num;
    z = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_table(i);
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_table(i);
      end
      x = nx;
    end
    return z;
  endfunction

  always @(posedge clk) begin
    longint ax, ay, az, mag, g, s, rate;
    longint tilt [3];
    angles_t got;
    angles_t want;
    if (!rst_n) begin
      alpha = GyroWeightRst;
      beta  = AccelWeightRst;
      dt    = TimeStepRst;
      for (int k = 0; k < 3; k++) held[k] = '0;
      expected_angles.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (paddr[CfgAddrW-1:2])
          RegGyroWeight:  alpha = pwdata[GyroWW-1:0];
          RegAccelWeight: beta  = pwdata[AccelWW-1:0];
          RegTimeStep:    dt    = pwdata[TimeStepW-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        // Axes are remapped before the tilt angles are formed.
        ax = -longint'(in_mon.accel_y);
        ay = longint'(in_mon.accel_x);
        az = longint'(in_mon.accel_z);
        if (ax != 0 || ay != 0 || az != 0) begin
          tilt[0] = tilt_deg(ax * 256, floor_root((ay * ay + az * az) << 16));
          tilt[1] = tilt_deg(ay * 256, floor_root((ax * ax + az * az) << 16));
          mag = floor_root((ax * ax + ay * ay) << 16);
          tilt[2] = (az < 0) ? -tilt_deg(mag, -az * 256) : tilt_deg(mag, az * 256);
          for (int k = 0; k < 3; k++) begin
            rate = (k == 0) ? longint'(in_mon.rate_x) :
                   (k == 1) ? longint'(in_mon.rate_y) : longint'(in_mon.rate_z);
            g = longint'(held[k]) + ((rate * longint'(dt) + 2048) >>> 12);
            s = (longint'(alpha) * g + longint'(beta) * tilt[k] + 32768) >>> 16;
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            held[k] = s[AngW-1:0];
          end
          expected_angles.push_back('{held[0], held[1], held[2]});
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.angle_x, out_mon.angle_y, out_mon.angle_z};
        if (expected_angles.size() == 0) begin
          $error("angle word with no sample pending: %0d %0d %0d",
                 got.ax, got.ay, got.az);
          fail_count++;
        end else begin
          want = expected_angles.pop_front();
          if (got.ax !== want.ax) begin
            $error("angle_x expected %0d actual %0d", want.ax, got.ax);
            fail_count++;
          end
          if (got.ay !== want.ay) begin
            $error("angle_y expected %0d actual %0d", want.ay, got.ay);
            fail_count++;
          end
          if (got.az !== want.az) begin
            $error("angle_z expected %0d actual %0d", want.az, got.az);
            fail_count++;
          end
        end
      end
    end
    angles_pending = expected_angles.size();
  end

endmodule

// ===== tb/sv/imu_tilt_complementary_filter_tb.sv =====
`timescale 1ns / 1ps
// Top of the IMU tilt filter testbench: clock, reset, sample stimulus,
// register writes and verdict. Depends on imuc_pkg, imuc_if and the checker.
module imu_tilt_complementary_filter_tb;
  import imuc_pkg::*;

  // Index three lies past the last register; writes there must be ignored.
  localparam logic [1:0] RegUnused = 2'd3;
  // A dropped sample never reaches the back end, so nothing is still in flight
  // when the last angle word comes out; the settle wait adds a margin.
  localparam int SettleCycles = 80;
  localparam int StallLimit   = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;
  logic idle_on = 1'b1;
  int   fail_count;
  int   angles_pending;
  int   quiet_cycles = 0;
  int   stall_left = 0;

  imuc_in_if  in_chan ();
  imuc_out_if out_chan ();

  always #10 clk = ~clk;

  imu_tilt_complementary_filter u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  imu_tilt_complementary_filter_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
    .angles_pending(angles_pending)
  );

  initial begin
    in_chan.valid = 1'b0;
    in_chan.accel_x = '0;
    in_chan.accel_y = '0;
    in_chan.accel_z = '0;
    in_chan.rate_x = '0;
    in_chan.rate_y = '0;
    in_chan.rate_z = '0;
    out_chan.ready = 1'b0;
  end

  // The result side stalls in random bursts while idling is enabled. Only
  // one assignment to ready is made per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_chan.ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Watchdog: too many cycles without any word moving means the block hung.
  always @(posedge clk) begin
    if (!rst_n || psel || (in_chan.valid && in_chan.ready) ||
        (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("imu_tilt_complementary_filter_tb: FAIL");
        $finish;
      end
    end
  end

  // Offers one sample word, maybe after a random gap, and holds it until it
  // is taken. Called right after a rising edge.
  task automatic send_sample(input logic [15:0] acx, input logic [15:0] acy,
                             input logic [15:0] acz, input logic [23:0] rx,
                             input logic [23:0] ry, input logic [23:0] rz);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.accel_x <= acx;
    in_chan.accel_y <= acy;
    in_chan.accel_z <= acz;
    in_chan.rate_x  <= rx;
    in_chan.rate_y  <= ry;
    in_chan.rate_z  <= rz;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Random sample: full-range fields mostly, with some small tilts, some vectors
  // with random axes cleared and the occasional all-zero vector that is dropped.
  task automatic send_random();
    logic [15:0] a [3];
    int pick;
    pick = $urandom_range(0, 19);
    for (int k = 0; k < 3; k++) a[k] = 16'($urandom());
    if (pick == 0) begin
      a = '{16'd0, 16'd0, 16'd0};
    end else if (pick < 4) begin
      for (int k = 0; k < 3; k++)
        if ($urandom_range(0, 1) == 0) a[k] = '0;
    end else if (pick < 8) begin
      for (int k = 0; k < 3; k++) a[k] = 16'($signed(10'($urandom())));
    end
    send_sample(a[0], a[1], a[2], 24'($urandom()), 24'($urandom()),
                24'($urandom()));
  endtask

  // Writes one register once the block has drained: every expected word has
  // arrived and the settle wait has passed.
  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (angles_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_weights(input logic [31:0] gw, input logic [31:0] aw,
                             input logic [31:0] ts);
    write_reg(RegGyroWeight, gw);
    write_reg(RegAccelWeight, aw);
    write_reg(RegTimeStep, ts);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset settings: gravity along each axis, zero
    // denominators, a negative z, extremes of every field, and the all-zero
    // accelerometer vector that must be dropped.
    send_sample(16'sd0, 16'sd0, 16'sd16384, 24'sd0, 24'sd0, 24'sd0);
    send_sample(16'sd0, 16'sd0, -16'sd16384, 24'sd256, -24'sd256, 24'sd0);
    send_sample(16'sd500, 16'sd0, 16'sd0, 24'sd0, 24'sd0, 24'sd0);
    send_sample(-16'sd500, 16'sd0, 16'sd0, 24'sd0, 24'sd0, 24'sd0);
    send_sample(16'sd0, 16'sd700, 16'sd0, 24'sd0, 24'sd0, 24'sd0);
    send_sample(16'sd0, -16'sd700, 16'sd0, 24'sd0, 24'sd0, 24'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_sample(16'h8000, 16'h8000, 16'h8000, 24'h800000, 24'h800000, 24'h800000);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_sample(16'h8000, 16'h7fff, 16'h0000, 24'h000001, 24'hffffff, 24'h7fffff);
    send_sample(16'sd1, 16'sd1, -16'sd1, 24'sd0, 24'sd0, 24'sd0);
    send_sample(16'sd3, -16'sd4, 16'sd12, 24'sd1000, 24'sd2000, -24'sd3000);

    // Extreme settings: all gyro weight and the longest step drive the
    // stored angles into saturation; then all accelerometer weight and no
    // step; an ignored write past the last register sits between them.
    set_weights(32'hffffffff, 32'd0, 32'hfffff);
    for (int i = 0; i < 6; i++)
      send_sample(16'sd100, 16'sd100, 16'sd100, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    for (int i = 0; i < 6; i++)
      send_sample(16'sd100, 16'sd100, 16'sd100, 24'h800000, 24'h800000, 24'h800000);
    for (int i = 0; i < 250; i++) send_random();
    write_reg(RegUnused, 32'h12345678);
    set_weights(32'd0, 32'd65535, 32'd0);
    for (int i = 0; i < 250; i++) send_random();

    set_weights($urandom(), $urandom(), $urandom());
    for (int i = 0; i < 250; i++) send_random();
    set_weights(32'd32768, 32'd32768, 32'd1);
    for (int i = 0; i < 250; i++) send_random();

    // Back to the reset values; the last stretch runs with no idling.
    set_weights(32'(GyroWeightRst), 32'(AccelWeightRst), 32'(TimeStepRst));
    for (int i = 0; i < 100; i++) send_random();
    idle_on <= 1'b0;
    for (int i = 0; i < 200; i++) send_random();
    in_chan.valid <= 1'b0;

    @(posedge clk);
    while (angles_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0 && angles_pending == 0) begin
      $display("imu_tilt_complementary_filter_tb: PASS");
    end else begin
      $display("imu_tilt_complementary_filter_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/imuc_pkg.sv
rtl/core/imuc_if.sv
rtl/core/imuc_front.sv
rtl/core/imuc_queue.sv
rtl/core/imuc_back.sv
rtl/core/imu_tilt_complementary_filter.sv
tb/sv/imu_tilt_complementary_filter_checker.sv
tb/sv/imu_tilt_complementary_filter_tb.sv
